// ----- hdl/afl_pkg.sv -----
// Shared types and codes for the addressed frame link node.
// No dependencies; imported by every module of the block.
package afl_pkg;

   // input operation codes
   localparam logic [1:0] OP_RX_BYTE = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_SEND    = 2'd2;
   localparam logic [1:0] OP_TX_BYTE = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_TX_BYTE   = 3'd0;
   localparam logic [2:0] KIND_RX_BYTE   = 3'd1;
   localparam logic [2:0] KIND_DONE      = 3'd2;
   localparam logic [2:0] KIND_ACK_SEEN  = 3'd3;
   localparam logic [2:0] KIND_TIMEOUT   = 3'd4;
   localparam logic [2:0] KIND_ABORT     = 3'd5;
   localparam logic [2:0] KIND_REJECTED  = 3'd6;

   // register indexes
   localparam logic [1:0] REG_OWN_ID      = 2'd0;
   localparam logic [1:0] REG_ACK_WAIT    = 2'd1;
   localparam logic [1:0] REG_READ_WINDOW = 2'd2;
   localparam logic [1:0] REG_ACK_CODE    = 2'd3;

   // receive phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam int          MAX_RESULTS = 7;
   localparam logic [15:0] READ_WINDOW_RESET = 16'd100;
   localparam logic [7:0]  BYTE_ZERO = 8'h00;
   localparam logic [15:0] COUNT_SAT = 16'hFFFF;

   // all results caused by one input item; header fields shared by the slots
   typedef struct packed {
      logic [MAX_RESULTS-1:0][2:0] kind;
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [MAX_RESULTS-1:0]      show_hdr;
      logic [7:0]                  peer_id;
      logic [7:0]                  frame_type;
      logic [15:0]                 frame_length;
      logic [2:0]                  count;
   } desc_type;

endpackage

// ----- hdl/addressed_frame_link_with_ack_core.sv -----
// Addressed frame link node with acknowledge: request channel (received
// bytes, millisecond ticks, send requests, send payload bytes), response
// channel of result items and a register write port.
// Usage:
//  - req_op selects the operation; a transfer happens when req_valid is high
//    and req_stall low. Node state updates on that edge.
//  - Each item gives zero to seven responses; rsp_last marks the final one.
//    Items that give no response leave no trace on the response channel.
//  - The first response is presented once the item's descriptor has passed
//    through the pending buffer register into the serialiser.
//  - Output rate: one response per cycle while rsp_stall is low; an item holds
//    the serialiser until its last response is taken. One further descriptor
//    is buffered, so a new request is taken while the previous one is still
//    being sent out.
//  - When the receiver raises rsp_stall, the response holds; req_stall is high
//    while the buffer is full and the serialiser cannot take it that cycle.
//  - csr_ready is always high; write registers only while no responses are
//    outstanding (0 own_id, 1 ack_wait_limit, 2 read_window, 3 ack_code).
//  - Synchronous reset clears all node state, buffers and registers
//    (read_window returns to 100).
module addressed_frame_link_with_ack_core import afl_pkg::*; #(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_byte_in,
   input  logic [7:0]  req_dest_id,
   input  logic [7:0]  req_send_type,
   input  logic [15:0] req_send_length,
   input  logic        req_want_ack,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_peer_id,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   desc_type desc;
   logic     desc_valid, desc_ready, accept;

   assign req_stall = !desc_ready;
   assign accept    = req_valid && desc_ready;
   assign csr_ready = 1'b1;

   afl_node #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_node (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_op),
      .byte_in     (req_byte_in),
      .dest_id     (req_dest_id),
      .send_type   (req_send_type),
      .send_length (req_send_length),
      .want_ack    (req_want_ack),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .desc        (desc),
      .desc_valid  (desc_valid)
   );

   afl_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .desc             (desc),
      .desc_valid       (desc_valid),
      .desc_ready       (desc_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_peer_id      (rsp_peer_id),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- hdl/afl_node.sv -----
// Node state, configuration registers and per-item result builder.
// Depends on afl_pkg.
module afl_node import afl_pkg::*; #(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  op,
   input  logic [7:0]  byte_in,
   input  logic [7:0]  dest_id,
   input  logic [7:0]  send_type,
   input  logic [15:0] send_length,
   input  logic        want_ack,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output desc_type    desc,
   output logic        desc_valid
);

   logic [7:0]  own_id_ff, ack_code_ff;
   logic [15:0] ack_wait_ff, read_window_ff;

   logic [1:0]       phase_ff, phase_in;
   logic [3:0][7:0]  hdr_ff, hdr_in;
   logic [15:0]      cnt_ff, cnt_in;
   logic [15:0]      wtimer_ff, wtimer_in;
   logic             awaiting_ff, awaiting_in;
   logic [15:0]      since_ff, since_in;
   logic [15:0]      txrem_ff, txrem_in;
   logic [15:0]      rxlen_ff, rxlen_in;

   logic [1:0]  phase_v;
   logic [15:0] cnt_v;
   logic [15:0] len_v;
   logic [15:0] wt_v, ss_v;
   logic        finish;
   logic [2:0]  n;
   desc_type    d;

   // config is to be written by the user only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff      <= '0;
         ack_wait_ff    <= '0;
         read_window_ff <= READ_WINDOW_RESET;
         ack_code_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_OWN_ID:      own_id_ff      <= csr_wdata[7:0];
            REG_ACK_WAIT:    ack_wait_ff    <= csr_wdata;
            REG_READ_WINDOW: read_window_ff <= csr_wdata;
            REG_ACK_CODE:    ack_code_ff    <= csr_wdata[7:0];
            default:         own_id_ff      <= own_id_ff;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      cnt_in      = cnt_ff;
      wtimer_in   = wtimer_ff;
      awaiting_in = awaiting_ff;
      since_in    = since_ff;
      txrem_in    = txrem_ff;
      rxlen_in    = rxlen_ff;
      phase_v     = phase_ff;
      cnt_v       = cnt_ff;
      len_v       = rxlen_ff;
      wt_v        = wtimer_ff;
      ss_v        = since_ff;
      finish      = 1'b0;
      n           = '0;
      d           = '0;
      d.peer_id   = hdr_ff[1];
      d.frame_type = hdr_ff[2];

      case (op)
         OP_RX_BYTE: begin
            if (phase_ff == PH_IDLE) begin
               phase_v   = PH_HEADER;
               cnt_v     = '0;
               wtimer_in = '0;
            end
            if (phase_v == PH_HEADER) begin
               if (cnt_v < 16'd4) begin
                  hdr_in[cnt_v[1:0]] = byte_in;
                  cnt_in   = cnt_v + 16'd1;
                  phase_in = PH_HEADER;
               end else begin
                  len_v    = {hdr_ff[3], byte_in};
                  rxlen_in = len_v;
                  if ({1'b0, len_v} > 17'(MAX_PAYLOAD)) begin
                     phase_in = PH_IDLE;
                     cnt_in   = '0;
                     d.kind[n] = KIND_ABORT;
                     d.show_hdr[n] = 1'b1;
                     n = n + 3'd1;
                  end else if (len_v == 16'd0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in  = PH_PAYLOAD;
                     cnt_in    = '0;
                     wtimer_in = '0;
                  end
               end
            end else begin
               cnt_in = cnt_ff + 16'd1;
               if (hdr_ff[0] == own_id_ff && hdr_ff[2] != ack_code_ff) begin
                  d.kind[n] = KIND_RX_BYTE;
                  d.data[n] = byte_in;
                  d.show_hdr[n] = 1'b1;
                  n = n + 3'd1;
               end
               if (cnt_in >= rxlen_ff) finish = 1'b1;
            end
            if (finish) begin
               phase_in = PH_IDLE;
               cnt_in   = '0;
               if (hdr_ff[0] == own_id_ff) begin
                  if (hdr_ff[2] == ack_code_ff) begin
                     awaiting_in = 1'b0;
                     d.kind[n] = KIND_ACK_SEEN;
                     d.show_hdr[n] = 1'b1;
                     n = n + 3'd1;
                  end else begin
                     if (hdr_ff[1] != own_id_ff) begin
                        // acknowledge frame back to the sender
                        d.kind[n] = KIND_TX_BYTE; d.data[n] = hdr_ff[1];
                        n = n + 3'd1;
                        d.kind[n] = KIND_TX_BYTE; d.data[n] = own_id_ff;
                        n = n + 3'd1;
                        d.kind[n] = KIND_TX_BYTE; d.data[n] = ack_code_ff;
                        n = n + 3'd1;
                        d.kind[n] = KIND_TX_BYTE; d.data[n] = BYTE_ZERO;
                        n = n + 3'd1;
                        d.kind[n] = KIND_TX_BYTE; d.data[n] = BYTE_ZERO;
                        n = n + 3'd1;
                     end
                     d.kind[n] = KIND_DONE;
                     d.show_hdr[n] = 1'b1;
                     n = n + 3'd1;
                  end
               end
            end
         end
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (wtimer_ff != COUNT_SAT) wt_v = wtimer_ff + 16'd1;
               wtimer_in = wt_v;
               if (wt_v >= read_window_ff) begin
                  d.kind[n] = KIND_ABORT;
                  d.show_hdr[n] = (phase_ff == PH_PAYLOAD);
                  n = n + 3'd1;
                  phase_in = PH_IDLE;
                  cnt_in   = '0;
               end
            end
            if (awaiting_ff) begin
               if (since_ff != COUNT_SAT) ss_v = since_ff + 16'd1;
               since_in = ss_v;
               if (ss_v > ack_wait_ff) begin
                  awaiting_in = 1'b0;
                  d.kind[n] = KIND_TIMEOUT;
                  n = n + 3'd1;
               end
            end
         end
         OP_SEND: begin
            if (txrem_ff != 16'd0 || {1'b0, send_length} > 17'(MAX_PAYLOAD) ||
                dest_id == own_id_ff) begin
               d.kind[n] = KIND_REJECTED;
               n = n + 3'd1;
            end else begin
               d.kind[n] = KIND_TX_BYTE; d.data[n] = dest_id;
               n = n + 3'd1;
               d.kind[n] = KIND_TX_BYTE; d.data[n] = own_id_ff;
               n = n + 3'd1;
               d.kind[n] = KIND_TX_BYTE; d.data[n] = send_type;
               n = n + 3'd1;
               d.kind[n] = KIND_TX_BYTE; d.data[n] = send_length[15:8];
               n = n + 3'd1;
               d.kind[n] = KIND_TX_BYTE; d.data[n] = send_length[7:0];
               n = n + 3'd1;
               txrem_in    = send_length;
               awaiting_in = want_ack;
               since_in    = '0;
            end
         end
         default: begin
            if (txrem_ff != 16'd0) begin
               txrem_in = txrem_ff - 16'd1;
               d.kind[n] = KIND_TX_BYTE;
               d.data[n] = byte_in;
               n = n + 3'd1;
            end
         end
      endcase

      d.frame_length = len_v;
      d.count        = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hdr_ff      <= '0;
         cnt_ff      <= '0;
         wtimer_ff   <= '0;
         awaiting_ff <= 1'b0;
         since_ff    <= '0;
         txrem_ff    <= '0;
         rxlen_ff    <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hdr_ff      <= hdr_in;
         cnt_ff      <= cnt_in;
         wtimer_ff   <= wtimer_in;
         awaiting_ff <= awaiting_in;
         since_ff    <= since_in;
         txrem_ff    <= txrem_in;
         rxlen_ff    <= rxlen_in;
      end
   end

   assign desc       = d;
   assign desc_valid = accept && (n != 3'd0);

endmodule

// ----- hdl/afl_emit.sv -----
// Result serialiser: one pending descriptor plus the one being sent out.
// Depends on afl_pkg.
module afl_emit import afl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  desc_type    desc,
   input  logic        desc_valid,
   output logic        desc_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_peer_id,
   output logic [7:0]  rsp_frame_type,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last
);

   desc_type   pend_ff, act_ff;
   logic       pend_full_ff, pend_full_in;
   logic       act_busy_ff, act_busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       take, last_take, move, is_last;

   assign is_last   = (idx_ff == act_ff.count - 3'd1);
   assign take      = act_busy_ff && !rsp_stall;
   assign last_take = take && is_last;
   assign move      = pend_full_ff && (!act_busy_ff || last_take);

   always_comb begin
      pend_full_in = pend_full_ff;
      act_busy_in  = act_busy_ff;
      idx_in       = idx_ff;
      if (desc_valid) pend_full_in = 1'b1;
      else if (move)  pend_full_in = 1'b0;
      if (move) begin
         act_busy_in = 1'b1;
         idx_in      = '0;
      end else if (last_take) begin
         act_busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_full_ff <= 1'b0;
         act_busy_ff  <= 1'b0;
         idx_ff       <= '0;
      end else begin
         pend_full_ff <= pend_full_in;
         act_busy_ff  <= act_busy_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_valid) pend_ff <= desc;
      if (move)       act_ff  <= pend_ff;
   end

   // buffer refills in the cycle its descriptor moves on
   assign desc_ready       = !pend_full_ff || move;
   assign rsp_valid        = act_busy_ff;
   assign rsp_kind         = act_ff.kind[idx_ff];
   assign rsp_data_byte    = act_ff.data[idx_ff];
   assign rsp_peer_id      = act_ff.show_hdr[idx_ff] ? act_ff.peer_id : 8'd0;
   assign rsp_frame_type   = act_ff.show_hdr[idx_ff] ? act_ff.frame_type : 8'd0;
   assign rsp_frame_length = act_ff.show_hdr[idx_ff] ? act_ff.frame_length : 16'd0;
   assign rsp_last         = is_last;

endmodule
